// ===== rtl/d2c_pkg.sv =====
// ----------------------------------------------------------------------------
// d2c_pkg
// Shared types and constants for the depth to color registration core.
// ----------------------------------------------------------------------------
package d2c_pkg;

    // configuration port
    localparam int IDX_W = 4;
    localparam int CFG_DW = 64;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DEPTH_FOCAL_INV = 4'd0;
    localparam logic [IDX_W-1:0] REG_DEPTH_CENTER    = 4'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_FOCAL     = 4'd2;
    localparam logic [IDX_W-1:0] REG_COLOR_CENTER    = 4'd3;
    localparam logic [IDX_W-1:0] REG_ROT_ROW_A       = 4'd4;
    localparam logic [IDX_W-1:0] REG_ROT_ROW_B       = 4'd5;
    localparam logic [IDX_W-1:0] REG_ROT_ROW_C       = 4'd6;
    localparam logic [IDX_W-1:0] REG_SHIFT_XYZ       = 4'd7;

    // fixed-point widths
    localparam int FW  = 21;   // rotation / translation field
    localparam int MW  = 59;   // back-projection product
    localparam int XW  = 39;   // camera point, Q.8
    localparam int PW  = 60;   // rotation product
    localparam int AW  = 62;   // rotation accumulator
    localparam int CW  = 44;   // rotated point, Q.8
    localparam int QPW = 61;   // projection product
    localparam int NW  = 62;   // projection numerator
    localparam int DNW = 48;   // divisor zc*16
    localparam int QW  = 12;   // quotient bits, covers frames up to 4096

    // rotation diagonal of one in Q2.18
    localparam logic [FW-1:0] ROT_ONE = 21'd262144;

    // stage counts
    localparam int BP_LAT  = 2;
    localparam int ROT_LAT = 2;
    localparam int PRJ_LAT = 4 + QW;
    localparam int TOT_LAT = BP_LAT + ROT_LAT + PRJ_LAT;

    // decoded configuration
    typedef struct packed {
        logic [23:0]              fxi;
        logic [23:0]              fyi;
        logic [15:0]              dcx;
        logic [15:0]              dcy;
        logic [15:0]              cfx;
        logic [15:0]              cfy;
        logic [15:0]              ccx;
        logic [15:0]              ccy;
        logic [2:0][2:0][FW-1:0]  rot;
        logic [2:0][FW-1:0]       tr;
    } cfg_t;

endpackage

// ===== rtl/d2c_intf.sv =====
// ----------------------------------------------------------------------------
// d2c channel interfaces
// Valid/ready channels for pixels, results and configuration writes.
// ----------------------------------------------------------------------------
interface d2c_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] pix_col;
    logic [9:0]  pix_row;
    logic [15:0] depth_val;
    modport source (output valid, pix_col, pix_row, depth_val, input ready);
    modport sink   (input valid, pix_col, pix_row, depth_val, output ready);
endinterface

interface d2c_res_if;
    logic        valid;
    logic        ready;
    logic [10:0] dst_col;
    logic [9:0]  dst_row;
    logic [10:0] src_col;
    logic [9:0]  src_row;
    logic        hit;
    modport source (output valid, dst_col, dst_row, src_col, src_row, hit, input ready);
    modport sink   (input valid, dst_col, dst_row, src_col, src_row, hit, output ready);
endinterface

interface d2c_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [d2c_pkg::IDX_W-1:0]   index;
    logic [d2c_pkg::CFG_DW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/depth_to_color_registration_core.sv =====
// ----------------------------------------------------------------------------
// depth_to_color_registration_core
// Maps a depth pixel to the color image pixel that sees the same point.
//
//   channel  dir  beat
//   cfg      in   index, data: one register write
//   pix      in   pix_col, pix_row, depth_val
//   res      out  dst_col, dst_row, src_col, src_row, hit
//
// One pixel per clock unless the output stalls. Stages: two back-projection
// stages, two rotation stages, four projection stages and one stage per
// quotient bit of the 12-bit divider. The whole pipeline advances when
// the output is empty or taken; a stall freezes every stage, so beats are
// held in place. Reset clears the valid bits and loads the identity rotation.
// ----------------------------------------------------------------------------
module depth_to_color_registration_core
#(
    parameter int unsigned DEPTH_WIDTH  = 1280,
    parameter int unsigned DEPTH_HEIGHT = 800,
    parameter int unsigned COLOR_WIDTH  = 1280,
    parameter int unsigned COLOR_HEIGHT = 800
)
(
    input  logic        clk,
    input  logic        rst_n,
    d2c_cfg_if.sink     cfg,
    d2c_pix_if.sink     pix,
    d2c_res_if.source   res
);

    localparam int TOT = d2c_pkg::TOT_LAT;

    d2c_pkg::cfg_t                  cfg_w;
    logic                           adv;
    logic                           v_reg [TOT];
    logic [10:0]                    col_reg [TOT];
    logic [9:0]                     row_reg [TOT];
    logic                           in_ok_reg [TOT];
    logic                           in_ok;
    logic signed [d2c_pkg::MW-1:0]  mx;
    logic signed [d2c_pkg::MW-1:0]  my;
    logic [15:0]                    d_bp;
    logic signed [d2c_pkg::CW-1:0]  pc [3];
    logic [d2c_pkg::QW-1:0]         qu;
    logic [d2c_pkg::QW-1:0]         qv;
    logic                           oku;
    logic                           okv;
    logic                           hit;

    d2c_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_w)
    );

    // pipeline advances when the output slot is free
    assign adv       = !v_reg[TOT-1] || res.ready;
    assign pix.ready = adv;

    // pixel must lie in the depth frame and carry a measurement
    assign in_ok = (pix.depth_val != 16'd0)
                && ({2'b00, pix.pix_col} < 13'(DEPTH_WIDTH))
                && ({3'b000, pix.pix_row} < 13'(DEPTH_HEIGHT));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= pix.valid;
            for (int i = 1; i < TOT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // side data traveling with the beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg[0]   <= pix.pix_col;
            row_reg[0]   <= pix.pix_row;
            in_ok_reg[0] <= in_ok;
            for (int i = 1; i < TOT; i++)
            begin
                col_reg[i]   <= col_reg[i-1];
                row_reg[i]   <= row_reg[i-1];
                in_ok_reg[i] <= in_ok_reg[i-1];
            end
        end
    end

    d2c_backproj u_bp
    (
        .clk  (clk),
        .adv  (adv),
        .col  (pix.pix_col),
        .row  (pix.pix_row),
        .dval (pix.depth_val),
        .cfg  (cfg_w),
        .mx   (mx),
        .my   (my),
        .dout (d_bp)
    );

    d2c_rotate u_rot
    (
        .clk  (clk),
        .adv  (adv),
        .mx   (mx),
        .my   (my),
        .dval (d_bp),
        .cfg  (cfg_w),
        .pc   (pc)
    );

    d2c_project #(.LIM(COLOR_WIDTH)) u_prj_u
    (
        .clk (clk),
        .adv (adv),
        .a   (pc[0]),
        .zc  (pc[2]),
        .f   (cfg_w.cfx),
        .c   (cfg_w.ccx),
        .q   (qu),
        .ok  (oku)
    );

    d2c_project #(.LIM(COLOR_HEIGHT)) u_prj_v
    (
        .clk (clk),
        .adv (adv),
        .a   (pc[1]),
        .zc  (pc[2]),
        .f   (cfg_w.cfy),
        .c   (cfg_w.ccy),
        .q   (qv),
        .ok  (okv)
    );

    // result beat
    assign hit         = in_ok_reg[TOT-1] && oku && okv;
    assign res.valid   = v_reg[TOT-1];
    assign res.dst_col = col_reg[TOT-1];
    assign res.dst_row = row_reg[TOT-1];
    assign res.src_col = hit ? qu[10:0] : 11'd0;
    assign res.src_row = hit ? qv[9:0] : 10'd0;
    assign res.hit     = hit;

endmodule

// ===== rtl/d2c_cfg.sv =====
// ----------------------------------------------------------------------------
// d2c_cfg
// Configuration register file, decoded into camera and pose fields.
// ----------------------------------------------------------------------------
module d2c_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    d2c_cfg_if.sink         cfg,
    output d2c_pkg::cfg_t   cfg_out
);

    d2c_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fxi <= '0;
            cfg_reg.fyi <= '0;
            cfg_reg.dcx <= '0;
            cfg_reg.dcy <= '0;
            cfg_reg.cfx <= '0;
            cfg_reg.cfy <= '0;
            cfg_reg.ccx <= '0;
            cfg_reg.ccy <= '0;
            // identity rotation, row 0 lowest
            cfg_reg.rot <= {{d2c_pkg::ROT_ONE, {(2 * d2c_pkg::FW){1'b0}}},
                            {{d2c_pkg::FW{1'b0}}, d2c_pkg::ROT_ONE, {d2c_pkg::FW{1'b0}}},
                            {{(2 * d2c_pkg::FW){1'b0}}, d2c_pkg::ROT_ONE}};
            cfg_reg.tr  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                d2c_pkg::REG_DEPTH_FOCAL_INV:
                begin
                    cfg_reg.fxi <= cfg.data[23:0];
                    cfg_reg.fyi <= cfg.data[47:24];
                end
                d2c_pkg::REG_DEPTH_CENTER:
                begin
                    cfg_reg.dcx <= cfg.data[15:0];
                    cfg_reg.dcy <= cfg.data[31:16];
                end
                d2c_pkg::REG_COLOR_FOCAL:
                begin
                    cfg_reg.cfx <= cfg.data[15:0];
                    cfg_reg.cfy <= cfg.data[31:16];
                end
                d2c_pkg::REG_COLOR_CENTER:
                begin
                    cfg_reg.ccx <= cfg.data[15:0];
                    cfg_reg.ccy <= cfg.data[31:16];
                end
                d2c_pkg::REG_ROT_ROW_A: cfg_reg.rot[0] <= cfg.data[62:0];
                d2c_pkg::REG_ROT_ROW_B: cfg_reg.rot[1] <= cfg.data[62:0];
                d2c_pkg::REG_ROT_ROW_C: cfg_reg.rot[2] <= cfg.data[62:0];
                d2c_pkg::REG_SHIFT_XYZ: cfg_reg.tr     <= cfg.data[62:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/d2c_backproj.sv =====
// ----------------------------------------------------------------------------
// d2c_backproj
// Two-stage back-projection products (c - pix) * d * (1/f).
// ----------------------------------------------------------------------------
module d2c_backproj
(
    input  logic                              clk,
    input  logic                              adv,
    input  logic [10:0]                       col,
    input  logic [9:0]                        row,
    input  logic [15:0]                       dval,
    input  d2c_pkg::cfg_t                     cfg,
    output logic signed [d2c_pkg::MW-1:0]     mx,
    output logic signed [d2c_pkg::MW-1:0]     my,
    output logic [15:0]                       dout
);

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] ds;
    logic signed [33:0] pdx_reg;
    logic signed [33:0] pdy_reg;
    logic [15:0]        d1_reg;
    logic signed [d2c_pkg::MW-1:0] mx_reg;
    logic signed [d2c_pkg::MW-1:0] my_reg;
    logic [15:0]        d2_reg;

    // offsets from the principal point, Q.4
    assign dx = $signed({1'b0, cfg.dcx}) - $signed({2'b00, col, 4'b0000});
    assign dy = $signed({1'b0, cfg.dcy}) - $signed({3'b000, row, 4'b0000});
    assign ds = $signed({1'b0, dval});

    // offset times depth
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdx_reg <= 34'(dx) * 34'(ds);
            pdy_reg <= 34'(dy) * 34'(ds);
            d1_reg  <= dval;
        end
    end

    // times inverse focal length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg <= d2c_pkg::MW'(pdx_reg) * d2c_pkg::MW'($signed({1'b0, cfg.fxi}));
            my_reg <= d2c_pkg::MW'(pdy_reg) * d2c_pkg::MW'($signed({1'b0, cfg.fyi}));
            d2_reg <= d1_reg;
        end
    end

    assign mx   = mx_reg;
    assign my   = my_reg;
    assign dout = d2_reg;

endmodule

// ===== rtl/d2c_rotate.sv =====
// ----------------------------------------------------------------------------
// d2c_rotate
// Rigid transform of the camera point: nine products, then row sums.
// ----------------------------------------------------------------------------
module d2c_rotate
(
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [d2c_pkg::MW-1:0]     mx,
    input  logic signed [d2c_pkg::MW-1:0]     my,
    input  logic [15:0]                       dval,
    input  d2c_pkg::cfg_t                     cfg,
    output logic signed [d2c_pkg::CW-1:0]     pc [3]
);

    logic signed [d2c_pkg::XW-1:0] pt [3];
    logic signed [d2c_pkg::PW-1:0] prod_reg [3][3];
    logic signed [d2c_pkg::AW-1:0] acc [3];
    logic signed [d2c_pkg::CW-1:0] pc_reg [3];

    // floor of the Q.28 products down to Q.8, z is depth in Q.8
    assign pt[0] = d2c_pkg::XW'(mx >>> 20);
    assign pt[1] = d2c_pkg::XW'(my >>> 20);
    assign pt[2] = $signed({15'd0, dval, 8'd0});

    // matrix entries times point
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= d2c_pkg::PW'($signed(cfg.rot[i][j]))
                                    * d2c_pkg::PW'(pt[j]);
                end
            end
        end
    end

    // row sums plus translation, back to Q.8
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = d2c_pkg::AW'(prod_reg[i][0]) + d2c_pkg::AW'(prod_reg[i][1])
                   + d2c_pkg::AW'(prod_reg[i][2])
                   + (d2c_pkg::AW'($signed(cfg.tr[i])) <<< 22);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i] <= d2c_pkg::CW'(acc[i] >>> 18);
            end
        end
    end

    assign pc = pc_reg;

endmodule

// ===== rtl/d2c_project.sv =====
// ----------------------------------------------------------------------------
// d2c_project
// Projection of one axis: numerator, range check and a pipelined
// restoring divider that yields one quotient bit per stage.
// ----------------------------------------------------------------------------
module d2c_project
#(
    parameter int unsigned LIM = 1280
)
(
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [d2c_pkg::CW-1:0]     a,
    input  logic signed [d2c_pkg::CW-1:0]     zc,
    input  logic [15:0]                       f,
    input  logic [15:0]                       c,
    output logic [d2c_pkg::QW-1:0]            q,
    output logic                              ok
);

    localparam int QW = d2c_pkg::QW;
    localparam int NW = d2c_pkg::NW;
    localparam int DNW = d2c_pkg::DNW;

    logic signed [d2c_pkg::QPW-1:0] af_reg;
    logic signed [d2c_pkg::QPW-1:0] cz_reg;
    logic signed [d2c_pkg::CW-1:0]  z5_reg;
    logic                           zp5_reg;
    logic signed [NW-1:0]           num6_reg;
    logic [DNW-1:0]                 den6_reg;
    logic                           zp6_reg;
    logic signed [NW-1:0]           num7_reg;
    logic [DNW-1:0]                 den7_reg;
    logic [NW-1:0]                  limden_reg;
    logic                           negfail_reg;
    logic                           zp7_reg;
    logic [NW-1:0]                  neg_mag;
    logic [NW-1:0]                  rem_reg [QW+1];
    logic [QW-1:0]                  q_reg [QW+1];
    logic [DNW-1:0]                 den_reg [QW+1];
    logic                           ok_reg [QW+1];
    logic [NW-1:0]                  trial [QW];

    // products of the numerator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            af_reg  <= d2c_pkg::QPW'(a) * d2c_pkg::QPW'($signed({1'b0, f}));
            cz_reg  <= d2c_pkg::QPW'($signed({1'b0, c})) * d2c_pkg::QPW'(zc);
            z5_reg  <= zc;
            zp5_reg <= (zc > 0);
        end
    end

    // numerator and divisor zc*16
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num6_reg <= NW'(cz_reg) - NW'(af_reg);
            den6_reg <= {z5_reg, 4'b0000};
            zp6_reg  <= zp5_reg;
        end
    end

    // negative quotient test and upper bound of the frame
    assign neg_mag = NW'(-num6_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num7_reg    <= num6_reg;
            den7_reg    <= den6_reg;
            limden_reg  <= NW'(d2c_pkg::QPW'(den6_reg) * d2c_pkg::QPW'(LIM));
            negfail_reg <= num6_reg[NW-1] && (neg_mag >= NW'(den6_reg));
            zp7_reg     <= zp6_reg;
        end
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k] = NW'(den_reg[k]) << (QW - 1 - k);
        end
    end

    // divider input (small negative values truncate to zero), then the bit stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num7_reg[NW-1] ? '0 : NW'(num7_reg);
            q_reg[0]   <= '0;
            den_reg[0] <= den7_reg;
            ok_reg[0]  <= zp7_reg && !negfail_reg
                        && !(!num7_reg[NW-1] && (NW'(num7_reg) >= limden_reg));
            for (int k = 0; k < QW; k++)
            begin
                if (rem_reg[k] >= trial[k])
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial[k];
                    q_reg[k+1]   <= q_reg[k] | (QW'(1) << (QW - 1 - k));
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
                den_reg[k+1] <= den_reg[k];
                ok_reg[k+1]  <= ok_reg[k];
            end
        end
    end

    assign q  = q_reg[QW];
    assign ok = ok_reg[QW];

endmodule

// ===== sim/tb_depth_to_color_registration_core.sv =====
// ----------------------------------------------------------------------------
// tb_depth_to_color_registration_core
// Drives depth pixels through the registration core under several camera
// calibrations and idling phases. Every result beat is checked field by field
// against an in-order queue of typed results or fixed-point predictions.
// ----------------------------------------------------------------------------
module tb_depth_to_color_registration_core;

    localparam int DW = 1280;
    localparam int DH = 800;
    localparam int CWID = 1280;
    localparam int CHGT = 800;
    localparam int NRAND = 1900;

    typedef struct packed {
        logic [10:0] dcol;
        logic [9:0]  drow;
        logic [10:0] scol;
        logic [9:0]  srow;
        logic        hit;
    } map_t;

    // one directed row: pixel, plus a typed-in result where obvious
    typedef struct {
        logic [10:0] col;
        logic [9:0]  row;
        logic [15:0] d;
        bit          typed;
        map_t        want;
    } drow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    d2c_cfg_if cfg ();
    d2c_pix_if pix ();
    d2c_res_if res ();

    depth_to_color_registration_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .pix   (pix.sink),
        .res   (res.source)
    );

    always #5 clk = ~clk;

    // calibration copy
    logic [63:0] cal [8];
    map_t        pending [$];
    int          n_bad = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    function automatic longint sx21(logic [63:0] r, int k);
        logic [20:0] f;
        f = r[21*k +: 21];
        return longint'(signed'(f));
    endfunction

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rot_row(logic [63:0] r, longint x, longint y, longint z,
                                       longint t);
        longint acc;
        acc = sx21(r, 0) * x + sx21(r, 1) * y + sx21(r, 2) * z + t * 4194304;
        return fshr(acc, 18);
    endfunction

    // color coordinate, or -1 when off frame
    function automatic longint proj(longint a, longint zc, longint f, longint c, longint lim);
        longint q;
        q = (-(a * f) + c * zc) / (zc * 16);
        return (q < 0 || q >= lim) ? -1 : q;
    endfunction

    function automatic map_t map_pixel(logic [10:0] col, logic [9:0] row, logic [15:0] d);
        map_t m;
        longint x, y, z, xc, yc, zc, u, v;
        m = '0;
        m.dcol = col;
        m.drow = row;
        if (d != 0 && col < DW && row < DH)
        begin
            x = fshr((longint'(cal[d2c_pkg::REG_DEPTH_CENTER][15:0]) - longint'(col) * 16)
                     * longint'(d) * longint'(cal[d2c_pkg::REG_DEPTH_FOCAL_INV][23:0]), 20);
            y = fshr((longint'(cal[d2c_pkg::REG_DEPTH_CENTER][31:16]) - longint'(row) * 16)
                     * longint'(d) * longint'(cal[d2c_pkg::REG_DEPTH_FOCAL_INV][47:24]), 20);
            z = longint'(d) * 256;
            xc = rot_row(cal[d2c_pkg::REG_ROT_ROW_A], x, y, z,
                         sx21(cal[d2c_pkg::REG_SHIFT_XYZ], 0));
            yc = rot_row(cal[d2c_pkg::REG_ROT_ROW_B], x, y, z,
                         sx21(cal[d2c_pkg::REG_SHIFT_XYZ], 1));
            zc = rot_row(cal[d2c_pkg::REG_ROT_ROW_C], x, y, z,
                         sx21(cal[d2c_pkg::REG_SHIFT_XYZ], 2));
            if (zc > 0)
            begin
                u = proj(xc, zc, longint'(cal[d2c_pkg::REG_COLOR_FOCAL][15:0]),
                         longint'(cal[d2c_pkg::REG_COLOR_CENTER][15:0]), CWID);
                v = proj(yc, zc, longint'(cal[d2c_pkg::REG_COLOR_FOCAL][31:16]),
                         longint'(cal[d2c_pkg::REG_COLOR_CENTER][31:16]), CHGT);
                if (u >= 0 && v >= 0)
                begin
                    m.hit = 1'b1;
                    m.scol = u[10:0];
                    m.srow = v[9:0];
                end
            end
        end
        return m;
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        map_t got, exp_m;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.dst_col, res.dst_row, res.src_col, res.src_row, res.hit};
            if (pending.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                exp_m = pending.pop_front();
                if (got !== exp_m)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %p, got %p", exp_m, got);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= recv_stall);
    end

    // one register write, then valid is dropped before the task returns
    task automatic cfg_write(logic [d2c_pkg::IDX_W-1:0] idx, logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
        case (idx) inside
            d2c_pkg::REG_DEPTH_FOCAL_INV: cal[idx] = val & 64'hFFFF_FFFF_FFFF;
            d2c_pkg::REG_DEPTH_CENTER, d2c_pkg::REG_COLOR_FOCAL, d2c_pkg::REG_COLOR_CENTER:
                cal[idx] = val & 64'hFFFF_FFFF;
            default: cal[idx] = val & 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
    endtask

    // one pixel beat; an optional typed result replaces the prediction
    // valid stays high on return so beats can follow back to back
    task automatic send_pixel(logic [10:0] col, logic [9:0] row, logic [15:0] d,
                              bit typed, map_t want);
        while ($urandom_range(99) < send_idle)
        begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid     <= 1'b1;
        pix.pix_col   <= col;
        pix.pix_row   <= row;
        pix.depth_val <= d;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        pending.push_back(typed ? want : map_pixel(col, row, d));
        @(negedge clk);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (d2c_pkg::TOT_LAT + 5) @(negedge clk);
    endtask

    function automatic logic [20:0] q218(int num, int den);
        return 21'(num * 262144 / den);
    endfunction

    // plausible camera pair with random small perturbations, or fully random registers when wild
    task automatic load_camera(bit wild);
        logic [63:0] r [3];
        logic [20:0] a, b;
        if (wild)
        begin
            cfg_write(d2c_pkg::REG_DEPTH_FOCAL_INV, {$urandom, $urandom});
            cfg_write(d2c_pkg::REG_DEPTH_CENTER, 64'($urandom));
            cfg_write(d2c_pkg::REG_COLOR_FOCAL, 64'($urandom));
            cfg_write(d2c_pkg::REG_COLOR_CENTER, 64'($urandom));
            cfg_write(d2c_pkg::REG_ROT_ROW_A, {$urandom, $urandom});
            cfg_write(d2c_pkg::REG_ROT_ROW_B, {$urandom, $urandom});
            cfg_write(d2c_pkg::REG_ROT_ROW_C, {$urandom, $urandom});
            cfg_write(d2c_pkg::REG_SHIFT_XYZ, {$urandom, $urandom});
        end
        else
        begin
            // focal near 600..1000 px, inverse in Q0.24
            cfg_write(d2c_pkg::REG_DEPTH_FOCAL_INV,
                      64'({24'(16777216 / $urandom_range(600, 1000)),
                           24'(16777216 / $urandom_range(600, 1000))}));
            cfg_write(d2c_pkg::REG_DEPTH_CENTER,
                      64'({16'($urandom_range(300, 500) * 16),
                           16'($urandom_range(540, 740) * 16)}));
            cfg_write(d2c_pkg::REG_COLOR_FOCAL, 64'({16'($urandom_range(9600, 16000)),
                                                     16'($urandom_range(9600, 16000))}));
            cfg_write(d2c_pkg::REG_COLOR_CENTER, 64'({16'($urandom_range(4800, 8000)),
                                                      16'($urandom_range(8240, 12240))}));
            a = q218(int'($urandom_range(0, 80)) - 40, 1000);
            b = q218(int'($urandom_range(0, 80)) - 40, 1000);
            r[0] = 64'({21'd0 - b, a, d2c_pkg::ROT_ONE});
            r[1] = 64'({21'd0 - a, d2c_pkg::ROT_ONE, 21'd0 - a});
            r[2] = 64'({d2c_pkg::ROT_ONE, a, b});
            cfg_write(d2c_pkg::REG_ROT_ROW_A, r[0]);
            cfg_write(d2c_pkg::REG_ROT_ROW_B, r[1]);
            cfg_write(d2c_pkg::REG_ROT_ROW_C, r[2]);
            cfg_write(d2c_pkg::REG_SHIFT_XYZ,
                      64'({21'(int'($urandom_range(0, 2000)) - 1000),
                           21'(int'($urandom_range(0, 2000)) - 1000),
                           21'(int'($urandom_range(0, 2000)) - 1000)}));
        end
    endtask

    initial
    begin
        drow_t dtab [$];
        map_t  miss;
        int    ph;
        int    k;
        logic [10:0] c;
        logic [9:0]  r;
        logic [15:0] d;

        pix.valid = 1'b0;
        pix.pix_col = '0;
        pix.pix_row = '0;
        pix.depth_val = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        res.ready = 1'b0;
        cal[d2c_pkg::REG_DEPTH_FOCAL_INV] = '0;
        cal[d2c_pkg::REG_DEPTH_CENTER] = '0;
        cal[d2c_pkg::REG_COLOR_FOCAL] = '0;
        cal[d2c_pkg::REG_COLOR_CENTER] = '0;
        cal[d2c_pkg::REG_ROT_ROW_A] = 64'd262144;
        cal[d2c_pkg::REG_ROT_ROW_B] = 64'd549755813888;
        cal[d2c_pkg::REG_ROT_ROW_C] = 64'd1152921504606846976;
        cal[d2c_pkg::REG_SHIFT_XYZ] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset calibration: X=Y=0, u=v=0 for any nonzero depth in frame
        dtab.push_back('{11'd0, 10'd0, 16'd1, 1, '{11'd0, 10'd0, 11'd0, 10'd0, 1'b1}});
        dtab.push_back('{11'd1279, 10'd799, 16'hFFFF, 1,
                         '{11'd1279, 10'd799, 11'd0, 10'd0, 1'b1}});
        // zero depth
        dtab.push_back('{11'd5, 10'd7, 16'd0, 1, '{11'd5, 10'd7, 11'd0, 10'd0, 1'b0}});
        // pixel outside depth frame
        dtab.push_back('{11'd1280, 10'd3, 16'd100, 1,
                         '{11'd1280, 10'd3, 11'd0, 10'd0, 1'b0}});
        dtab.push_back('{11'd2047, 10'd1023, 16'd100, 1,
                         '{11'd2047, 10'd1023, 11'd0, 10'd0, 1'b0}});
        dtab.push_back('{11'd3, 10'd800, 16'd100, 1, '{11'd3, 10'd800, 11'd0, 10'd0, 1'b0}});
        foreach (dtab[i])
            send_pixel(dtab[i].col, dtab[i].row, dtab[i].d, 1'b1, dtab[i].want);
        drain();

        // negative Z: flip rotation row c
        cfg_write(d2c_pkg::REG_ROT_ROW_C, 64'({21'h1FFFFF - d2c_pkg::ROT_ONE + 21'd1, 42'd0}));
        miss = '{11'd10, 10'd10, 11'd0, 10'd0, 1'b0};
        send_pixel(11'd10, 10'd10, 16'd500, 1'b1, miss);
        drain();
        // zero Z via cancelling shift
        cfg_write(d2c_pkg::REG_ROT_ROW_C, 64'({d2c_pkg::ROT_ONE, 42'd0}));
        cfg_write(d2c_pkg::REG_SHIFT_XYZ, 64'({21'h1FFFFF - 21'd8000 + 21'd1, 42'd0}));
        send_pixel(11'd10, 10'd10, 16'd500, 1'b1, miss);
        drain();

        // typical calibration and then camera extremes, predicted
        load_camera(1'b0);
        dtab.delete();
        dtab.push_back('{11'd0, 10'd0, 16'd1, 0, miss});
        dtab.push_back('{11'd1279, 10'd0, 16'd800, 0, miss});
        dtab.push_back('{11'd0, 10'd799, 16'd65535, 0, miss});
        dtab.push_back('{11'd640, 10'd400, 16'd1000, 0, miss});
        dtab.push_back('{11'd1279, 10'd799, 16'd3000, 0, miss});
        dtab.push_back('{11'd300, 10'd500, 16'd32768, 0, miss});
        foreach (dtab[i])
            send_pixel(dtab[i].col, dtab[i].row, dtab[i].d, 1'b0, miss);
        drain();
        cfg_write(d2c_pkg::REG_DEPTH_FOCAL_INV, 64'hFFFF_FFFF_FFFF);
        cfg_write(d2c_pkg::REG_DEPTH_CENTER, 64'hFFFF_FFFF);
        cfg_write(d2c_pkg::REG_COLOR_FOCAL, 64'hFFFF_FFFF);
        cfg_write(d2c_pkg::REG_COLOR_CENTER, 64'hFFFF_FFFF);
        cfg_write(d2c_pkg::REG_ROT_ROW_A, 64'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(d2c_pkg::REG_ROT_ROW_B, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
        cfg_write(d2c_pkg::REG_ROT_ROW_C, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
        cfg_write(d2c_pkg::REG_SHIFT_XYZ, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
        foreach (dtab[i])
            send_pixel(dtab[i].col, dtab[i].row, dtab[i].d, 1'b0, miss);
        drain();

        // random phases, each with its own calibration and idling mix
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 69;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 69;
                end
                default:
                begin
                    send_idle = 36;
                    recv_stall = 36;
                end
            endcase
            load_camera(ph == 5);
            for (k = 0; k < NRAND / 8; k++)
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        c = 11'($urandom);
                        r = 10'($urandom);
                        d = 16'($urandom);
                    end
                    1:
                    begin
                        c = 11'($urandom_range(0, DW - 1));
                        r = 10'($urandom_range(0, DH - 1));
                        d = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
                    end
                    default:
                    begin
                        c = 11'($urandom_range(0, DW - 1));
                        r = 10'($urandom_range(0, DH - 1));
                        d = 16'($urandom_range(300, 8000));
                    end
                endcase
                send_pixel(c, r, d, 1'b0, miss);
            end
            drain();
        end

        if (n_bad == 0)
            $display("tb_depth_to_color_registration_core: PASS");
        else
            $display("tb_depth_to_color_registration_core: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_depth_to_color_registration_core: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/d2c_pkg.sv
rtl/d2c_intf.sv
rtl/d2c_cfg.sv
rtl/d2c_backproj.sv
rtl/d2c_rotate.sv
rtl/d2c_project.sv
rtl/depth_to_color_registration_core.sv
sim/tb_depth_to_color_registration_core.sv
